// ===== hdl/a85_pkg.sv =====
package a85_pkg;

    localparam int B85_BASE = 85;
    localparam logic [6:0] B85_OFFSET = 7'd33;
    localparam logic [6:0] B85_ZERO_CHAR = 7'd122;

    // q = (v * B85_RECIP) >> B85_SHIFT is exact for every 32-bit v
    localparam logic [31:0] B85_RECIP = 32'hC0C0C0C1;
    localparam int B85_SHIFT = 38;

    localparam int NUM_DIGITS = 5;
    localparam int DIG_IDX_W = $clog2(NUM_DIGITS);
    localparam logic [DIG_IDX_W-1:0] LAST_STEP = DIG_IDX_W'(NUM_DIGITS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0]          value;
        logic [DIG_IDX_W-1:0] ndig;
        logic                 zero;
    } t_job;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } t_cv_state;

    // 256 = 1 mod 85, so the residue follows from the byte sum
    function automatic logic [6:0] mod85(input logic [31:0] v);
        logic [9:0] s;
        logic [8:0] t;
        s = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
        t = 9'(s[9:8]) + 9'(s[7:0]);
        if (t >= 9'(3 * B85_BASE)) begin
            return 7'(t - 9'(3 * B85_BASE));
        end else if (t >= 9'(2 * B85_BASE)) begin
            return 7'(t - 9'(2 * B85_BASE));
        end else if (t >= 9'(B85_BASE)) begin
            return 7'(t - 9'(B85_BASE));
        end else begin
            return 7'(t);
        end
    endfunction

endpackage

// ===== hdl/a85_front.sv =====
module a85_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_stream,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output a85_pkg::t_job  o_job
);
    import a85_pkg::*;

    logic [23:0] r_word;
    logic [1:0]  r_count;
    logic        full_group;
    logic        job_needed;
    logic        accept;
    logic [31:0] packed_val;

    assign full_group = (r_count == 2'd3);
    assign job_needed = full_group || i_end_of_stream;
    assign o_ready = !job_needed || i_job_ready;
    assign accept = i_valid && o_ready;
    assign o_job_valid = i_valid && job_needed;

    always_comb begin
        o_job.zero = 1'b0;
        o_job.ndig = DIG_IDX_W'(NUM_DIGITS);
        packed_val = {r_word, i_data_byte};
        case (r_count)
            2'd0: o_job.value = {i_data_byte, 24'd0};
            2'd1: o_job.value = {r_word[7:0], i_data_byte, 16'd0};
            2'd2: o_job.value = {r_word[15:0], i_data_byte, 8'd0};
            default: o_job.value = packed_val;
        endcase
        if (full_group) begin
            o_job.zero = (packed_val == 32'd0);
        end else begin
            // partial group sends one digit more than it has bytes
            o_job.ndig = DIG_IDX_W'(r_count) + DIG_IDX_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= 24'd0;
            r_count <= 2'd0;
        end else if (accept) begin
            if (job_needed) begin
                r_word <= 24'd0;
                r_count <= 2'd0;
            end else begin
                r_word <= {r_word[15:0], i_data_byte};
                r_count <= r_count + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/a85_queue.sv =====
module a85_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  a85_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_pop,
    output a85_pkg::t_job  o_job
);
    import a85_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/a85_back.sv =====
module a85_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_pop,
    input  a85_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [6:0]     o_out_char,
    output logic           o_run_last
);
    import a85_pkg::*;

    // digit converter
    t_cv_state            r_cv_state;
    t_cv_state            n_cv_state;
    logic [31:0]          r_cv_val;
    logic [DIG_IDX_W-1:0] r_cv_step;
    logic [DIG_IDX_W-1:0] r_cv_ndig;
    logic                 r_cv_zero;
    logic [6:0]           r_cv_dig [NUM_DIGITS];
    logic                 cv_load;
    logic [63:0]          cv_prod;
    logic [31:0]          cv_quot;
    logic [DIG_IDX_W-1:0] cv_idx;

    // character emitter
    logic                 r_em_busy;
    logic [DIG_IDX_W-1:0] r_em_idx;
    logic [DIG_IDX_W-1:0] r_em_ndig;
    logic                 r_em_zero;
    logic [6:0]           r_em_dig [NUM_DIGITS];
    logic                 em_last;
    logic                 em_fire;
    logic                 em_take;
    logic                 out_free;

    logic                 r_o_valid;
    logic [6:0]           r_o_char;
    logic                 r_o_last;

    assign cv_prod = 64'(r_cv_val) * 64'(B85_RECIP);
    assign cv_quot = 32'(cv_prod >> B85_SHIFT);
    // digits come out least significant first
    assign cv_idx = LAST_STEP - r_cv_step;

    assign out_free = !r_o_valid || i_ready;
    assign em_last = r_em_zero || (r_em_idx == r_em_ndig - DIG_IDX_W'(1));
    assign em_fire = r_em_busy && out_free;
    assign em_take = (r_cv_state == CV_DONE) && (!r_em_busy || (em_fire && em_last));
    assign o_job_pop = cv_load;

    always_comb begin
        n_cv_state = r_cv_state;
        cv_load = 1'b0;
        unique case (r_cv_state)
            CV_IDLE: begin
                if (i_job_valid) begin
                    cv_load = 1'b1;
                    n_cv_state = CV_RUN;
                end
            end
            CV_RUN: begin
                if (r_cv_step == LAST_STEP) begin
                    n_cv_state = CV_DONE;
                end
            end
            CV_DONE: begin
                if (em_take) begin
                    if (i_job_valid) begin
                        cv_load = 1'b1;
                        n_cv_state = CV_RUN;
                    end else begin
                        n_cv_state = CV_IDLE;
                    end
                end
            end
            default: n_cv_state = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_state <= CV_IDLE;
        end else begin
            r_cv_state <= n_cv_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cv_load) begin
            r_cv_val <= i_job.value;
            r_cv_ndig <= i_job.ndig;
            r_cv_zero <= i_job.zero;
            r_cv_step <= '0;
        end else if (r_cv_state == CV_RUN) begin
            r_cv_val <= cv_quot;
            r_cv_dig[cv_idx] <= mod85(r_cv_val) + B85_OFFSET;
            r_cv_step <= r_cv_step + DIG_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_busy <= 1'b0;
        end else if (em_take) begin
            r_em_busy <= 1'b1;
        end else if (em_fire && em_last) begin
            r_em_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_take) begin
            r_em_idx <= '0;
            r_em_ndig <= r_cv_ndig;
            r_em_zero <= r_cv_zero;
            r_em_dig <= r_cv_dig;
        end else if (em_fire) begin
            r_em_idx <= r_em_idx + DIG_IDX_W'(1);
        end
    end

    // output register: holds one beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (em_fire) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_o_char <= r_em_zero ? B85_ZERO_CHAR : r_em_dig[r_em_idx];
            r_o_last <= em_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out_char = r_o_char;
    assign o_run_last = r_o_last;

endmodule

// ===== hdl/ascii85_encoder.sv =====
// Ascii85 stream encoder. One raw byte is taken per input beat, flagged on the
// last byte of a stream; every fourth byte completes a big-endian group that
// comes out as five characters (33 plus a base-85 digit, most significant
// first), or as a single 'z' when the group is zero. A stream that ends on a
// partial group of n bytes is zero-padded and gives its first n+1 characters.
// o_run_last marks the final character of each group's output. Bytes that do
// not close a group are taken every cycle; a closing byte waits only when the
// two-entry group queue is full. Each group, partial ones too, occupies the
// digit converter for all of its digit steps (one reciprocal multiply by 1/85
// per digit) and then until the emitter takes its digits, so a new group can
// be converted while the previous one is still being emitted. A group's
// characters leave at one per cycle while the sink accepts them. The closing
// byte of a group passes through the group queue, the converter steps and the
// emitter hand-off before its first character reaches the output register.
module ascii85_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_out_char,
    output logic       o_run_last
);
    import a85_pkg::*;

    t_job fr_job;
    t_job bk_job;
    logic fr_job_valid;
    logic q_ready;
    logic q_valid;
    logic bk_pop;

    a85_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_job_valid     (fr_job_valid),
        .i_job_ready     (q_ready),
        .o_job           (fr_job)
    );

    a85_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_job_valid),
        .o_ready (q_ready),
        .i_job   (fr_job),
        .o_valid (q_valid),
        .i_pop   (bk_pop),
        .o_job   (bk_job)
    );

    a85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (bk_pop),
        .i_job       (bk_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== dv/ascii85_encoder_tb.sv =====
`timescale 1ns / 1ps

module ascii85_encoder_tb;

    import a85_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_enc_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_end_of_stream = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [6:0] o_out_char;
    logic       o_run_last;

    // encoder state as the predictor tracks it
    logic [23:0] grp_word = '0;
    logic [1:0]  grp_cnt = '0;

    t_enc_char pending_chars[$];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        sender_idles = 1'b1;
    bit        sink_stalls = 1'b1;

    ascii85_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_run_last      (o_run_last)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // queue the first count base-85 digits of value, most significant first
    function automatic void push_digits(input logic [31:0] value, input int count);
        logic [6:0]  dig [5];
        logic [31:0] v;
        t_enc_char   c;
        v = value;
        for (int i = 4; i >= 0; i--) begin
            dig[i] = 7'(v % B85_BASE);
            v = v / B85_BASE;
        end
        for (int i = 0; i < count; i++) begin
            c.ch = dig[i] + B85_OFFSET;
            c.last = (i == count - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic eos);
        logic [31:0] value;
        t_enc_char   c;
        value = {grp_word, b};
        if (grp_cnt == 2'd3) begin
            grp_word = '0;
            grp_cnt = '0;
            if (value == 32'd0) begin
                c.ch = B85_ZERO_CHAR;
                c.last = 1'b1;
                pending_chars.push_back(c);
            end else begin
                push_digits(value, 5);
            end
        end else if (!eos) begin
            grp_word = {grp_word[15:0], b};
            grp_cnt = grp_cnt + 2'd1;
        end else begin
            // short final group: pad with zeros, no 'z' shortcut
            value = value << (8 * (3 - int'(grp_cnt)));
            push_digits(value, int'(grp_cnt) + 2);
            grp_word = '0;
            grp_cnt = '0;
        end
    endfunction

    always @(posedge i_clk) begin : monitor_blk
        t_enc_char want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                encode_byte(i_data_byte, i_end_of_stream);
            end
            if (o_valid && i_ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %0d", o_out_char));
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_char !== want.ch) begin
                        report_mismatch($sformatf("out_char %0d, want %0d",
                                                  o_out_char, want.ch));
                    end
                    if (o_run_last !== want.last) begin
                        report_mismatch($sformatf("run_last %0b, want %0b (char %0d)",
                                                  o_run_last, want.last, want.ch));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= sink_stalls ? ($urandom_range(99) >= 23) : 1'b1;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (sender_idles) begin
            while ($urandom_range(99) < 23) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(input int flavor);
        case (flavor)
            0: return 8'($urandom);
            1: return ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
            2: return $urandom_range(1) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(7));
        endcase
    endfunction

    task automatic send_random_stream(output int sent);
        int len;
        int flavor;
        len = ($urandom_range(99) < 10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        flavor = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(flavor), i == len - 1);
        end
        sent = len;
    endtask

    task automatic test_zero_groups();
        repeat (4) send_byte(8'h00, 1'b0);
        // full zero group that also closes the stream
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_full_scale_group();
        repeat (3) send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        // low digit at its maximum
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'd84, 1'b1);
    endtask

    task automatic test_partial_groups();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        // zero padded tail never turns into 'z'
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b1);
    endtask

    task automatic test_random_streams(input int n_bytes);
        int total;
        int sent;
        total = 0;
        while (total < n_bytes) begin
            send_random_stream(sent);
            total += sent;
        end
    endtask

    task automatic test_back_to_back(input int n_bytes);
        sender_idles = 1'b0;
        sink_stalls = 1'b0;
        test_random_streams(n_bytes);
        sender_idles = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_groups();
        test_full_scale_group();
        test_partial_groups();
        test_random_streams(260);
        test_back_to_back(100);
        test_random_streams(80);

        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== ascii85_encoder.f =====
hdl/a85_pkg.sv
hdl/a85_front.sv
hdl/a85_queue.sv
hdl/a85_back.sv
hdl/ascii85_encoder.sv
dv/ascii85_encoder_tb.sv
